// ===== hdl/vmmt_pkg.sv =====
// shared types and constants of the value/mask merge table
package vmmt_pkg;

    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_VALUE_BITS    = 32;
    localparam int AGE_BITS          = 32;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_SPARE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_COVERED = 3'd0,
        ST_STORED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_CLEARED = 3'd3,
        ST_VALID   = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_CLEAR
    } state_t;

    // one finished result handed to the output stage
    typedef struct packed {
        status_t     status;
        logic [31:0] entry_value;
        logic [31:0] entry_mask;
        logic [31:0] entry_age;
        logic [6:0]  entry_count;
    } result_t;

endpackage

// ===== hdl/vmmt_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
module vmmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/vmmt_engine.sv =====
// sequencer: table scans, merge, store, clear and slot read
module vmmt_engine #(
    parameter int TABLE_ENTRIES = vmmt_pkg::DEF_TABLE_ENTRIES,
    parameter int VALUE_BITS    = vmmt_pkg::DEF_VALUE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  vmmt_pkg::opcode_t                      op,
    input  logic [VALUE_BITS-1:0]                  value,
    input  logic [5:0]                             slot,
    output logic                                   idle,
    output logic                                   ram_wr_en,
    output logic [$clog2(TABLE_ENTRIES)-1:0]       ram_wr_addr,
    output logic [2*VALUE_BITS+vmmt_pkg::AGE_BITS:0] ram_wr_data,
    output logic [$clog2(TABLE_ENTRIES)-1:0]       ram_rd_addr,
    input  logic [2*VALUE_BITS+vmmt_pkg::AGE_BITS:0] ram_rd_data,
    output logic                                   res_valid,
    output vmmt_pkg::result_t                      res
);
    import vmmt_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [VALUE_BITS-1:0] ALL_ONES = {VALUE_BITS{1'b1}};
    localparam logic [IW:0] LAST = (IW + 1)'(TABLE_ENTRIES);
    localparam logic [IW:0] LAST_SLOT = (IW + 1)'(TABLE_ENTRIES - 1);

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] v_reg, v_next, m_reg, m_next, best_val_reg, best_val_next;
    logic [AGE_BITS-1:0]   best_age_reg, best_age_next, age_reg, age_next;
    logic [IW:0]           issue_reg, issue_next;
    logic                  pipe_vld_reg, pipe_vld_next;
    logic [IW-1:0]         pipe_idx_reg, pipe_idx_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next, free_idx_reg, free_idx_next;
    logic                  cov_reg, cov_next, found_reg, found_next;
    logic                  free_reg, free_next, first_reg, first_next;
    logic                  clr_rsp_reg, clr_rsp_next;
    logic [31:0]           slot_reg, slot_next;
    logic [CW-1:0]         count_reg, count_next;

    logic [VALUE_BITS-1:0] rd_val, rd_mask, diff;
    logic [AGE_BITS-1:0]   rd_age;
    logic                  rd_vb, one_apart;
    logic [31:0]           count32, slot32;

    assign rd_vb     = ram_rd_data[2*VALUE_BITS+AGE_BITS];
    assign rd_val    = ram_rd_data[2*VALUE_BITS+AGE_BITS-1 -: VALUE_BITS];
    assign rd_mask   = ram_rd_data[VALUE_BITS+AGE_BITS-1 -: VALUE_BITS];
    assign rd_age    = ram_rd_data[AGE_BITS-1:0];
    assign diff      = v_reg ^ rd_val;
    assign one_apart = (diff != '0) && ((diff & (diff - 1'b1)) == '0);
    assign count32   = 32'(count_reg);
    assign slot32    = 32'(slot);
    assign idle      = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        v_next        = v_reg;
        m_next        = m_reg;
        best_val_next = best_val_reg;
        best_age_next = best_age_reg;
        best_idx_next = best_idx_reg;
        age_next      = age_reg;
        issue_next    = issue_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = issue_reg[IW-1:0];
        free_idx_next = free_idx_reg;
        cov_next      = cov_reg;
        found_next    = found_reg;
        free_next     = free_reg;
        first_next    = first_reg;
        clr_rsp_next  = clr_rsp_reg;
        slot_next     = slot_reg;
        count_next    = count_reg;
        ram_rd_addr   = issue_reg[IW-1:0];
        ram_wr_en     = 1'b0;
        ram_wr_addr   = free_idx_reg;
        ram_wr_data   = {1'b1, v_reg, m_reg, age_reg};
        res_valid     = 1'b0;
        res           = '0;
        res.entry_count = count32[6:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_ADD:
                        begin
                            v_next     = value;
                            m_next     = ALL_ONES;
                            first_next = 1'b1;
                            issue_next = '0;
                            cov_next   = 1'b0;
                            found_next = 1'b0;
                            free_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            issue_next   = '0;
                            clr_rsp_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                            ram_rd_addr = slot32[IW-1:0];
                            slot_next   = slot32;
                            state_next  = S_READ;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_valid  = 1'b1;
                state_next = S_IDLE;
                if ((slot_reg < 32'(TABLE_ENTRIES)) && rd_vb)
                begin
                    res.status      = ST_VALID;
                    res.entry_value = 32'(rd_val);
                    res.entry_mask  = 32'(rd_mask);
                    res.entry_age   = rd_age;
                end
                else
                begin
                    res.status = ST_EMPTY;
                end
            end
            S_CLEAR:
            begin
                // one slot written empty a cycle
                ram_wr_en   = 1'b1;
                ram_wr_addr = issue_reg[IW-1:0];
                ram_wr_data = '0;
                issue_next  = issue_reg + 1'b1;
                if (issue_reg == LAST_SLOT)
                begin
                    issue_next   = '0;
                    clr_rsp_next = 1'b0;
                    state_next   = S_IDLE;
                    if (clr_rsp_reg)
                    begin
                        count_next      = '0;
                        res_valid       = 1'b1;
                        res.status      = ST_CLEARED;
                        res.entry_count = '0;
                    end
                end
            end
            S_SCAN:
            begin
                // issue reads one slot a cycle
                if (issue_reg != LAST)
                begin
                    issue_next    = issue_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                end
                // examine the slot read last cycle
                if (pipe_vld_reg)
                begin
                    if (rd_vb)
                    begin
                        if (rd_mask != ALL_ONES && (rd_val & rd_mask) == (v_reg & rd_mask))
                        begin
                            cov_next = 1'b1;
                        end
                        if (rd_mask == m_reg && one_apart &&
                            (!found_reg || rd_age < best_age_reg))
                        begin
                            found_next    = 1'b1;
                            best_idx_next = pipe_idx_reg;
                            best_age_next = rd_age;
                            best_val_next = rd_val;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = pipe_idx_reg;
                    end
                end
                else if (issue_reg == LAST)
                begin
                    // end of pass
                    issue_next = '0;
                    cov_next   = 1'b0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    if (first_reg && cov_reg)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_COVERED;
                        state_next = S_IDLE;
                    end
                    else if (found_reg)
                    begin
                        // partner slot becomes empty
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = best_idx_reg;
                        ram_wr_data = '0;
                        count_next  = count_reg - 1'b1;
                        m_next      = m_reg & ~(v_reg ^ best_val_reg);
                        v_next      = (best_val_reg < v_reg) ? best_val_reg : v_reg;
                        first_next  = 1'b0;
                    end
                    else
                    begin
                        res_valid       = 1'b1;
                        res.entry_value = 32'(v_reg);
                        res.entry_mask  = 32'(m_reg);
                        state_next      = S_IDLE;
                        if (free_reg)
                        begin
                            ram_wr_en       = 1'b1;
                            count_next      = count_reg + 1'b1;
                            age_next        = age_reg + 1'b1;
                            res.status      = ST_STORED;
                            res.entry_age   = age_reg;
                            res.entry_count = 7'(count32 + 32'd1);
                        end
                        else
                        begin
                            res.status = ST_FULL;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            count_reg    <= '0;
            age_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            issue_reg    <= '0;
            cov_reg      <= 1'b0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            first_reg    <= 1'b0;
            clr_rsp_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            age_reg      <= age_next;
            pipe_vld_reg <= pipe_vld_next;
            issue_reg    <= issue_next;
            cov_reg      <= cov_next;
            found_reg    <= found_next;
            free_reg     <= free_next;
            first_reg    <= first_next;
            clr_rsp_reg  <= clr_rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        m_reg        <= m_next;
        best_val_reg <= best_val_next;
        best_age_reg <= best_age_next;
        best_idx_reg <= best_idx_next;
        free_idx_reg <= free_idx_next;
        pipe_idx_reg <= pipe_idx_next;
        slot_reg     <= slot_next;
    end

endmodule

// ===== hdl/value_mask_merge_table_unit.sv =====
// top level of the value/mask merge table: handshakes, output register, table ram
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+---------------------------------------------------
//  command | cmd_valid | cmd_ready | opcode, value, slot
//  result  | rsp_valid | rsp_ready | status, entry_value, entry_mask, entry_age, entry_count
//
// one transaction at a time; the next command is taken once the result has left.
// clear: one slot written empty a cycle. read slot: a single registered ram read.
// add: (merges + 1) passes over the table, each reading every slot through the single
// ram read port; at most VALUE_BITS + 1 passes.
// reset starts a clearing pass over every slot; commands wait until it ends.
// a stalled result holds the output register and keeps cmd_ready low.
module value_mask_merge_table_unit #(
    parameter int TABLE_ENTRIES = vmmt_pkg::DEF_TABLE_ENTRIES,
    parameter int VALUE_BITS    = vmmt_pkg::DEF_VALUE_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] value,
    input  logic [5:0]  slot,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  status,
    output logic [31:0] entry_value,
    output logic [31:0] entry_mask,
    output logic [31:0] entry_age,
    output logic [6:0]  entry_count
);
    import vmmt_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    // valid bit, value, mask, age
    localparam int DW = 2 * VALUE_BITS + AGE_BITS + 1;

    logic          eng_idle, start, res_valid;
    logic          ram_wr_en;
    logic [IW-1:0] ram_wr_addr, ram_rd_addr;
    logic [DW-1:0] ram_wr_data, ram_rd_data;
    result_t       res, out_reg;
    logic          out_vld_reg;

    // accept only when the engine is idle and no result is pending
    assign cmd_ready = eng_idle && !out_vld_reg;
    assign start     = cmd_valid && cmd_ready;

    vmmt_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    vmmt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VALUE_BITS    (VALUE_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (opcode_t'(opcode)),
        .value       (value[VALUE_BITS-1:0]),
        .slot        (slot),
        .idle        (eng_idle),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register, held until the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid   = out_vld_reg;
    assign status      = out_reg.status;
    assign entry_value = out_reg.entry_value;
    assign entry_mask  = out_reg.entry_mask;
    assign entry_age   = out_reg.entry_age;
    assign entry_count = out_reg.entry_count;

endmodule
